/* rtl/clsv_pkg.sv */
// Shared types and constants of the cross-lane sync voter.
// No dependencies; used by every module of the block through scoped names.
package clsv_pkg;

  localparam int MAX_LANES = 4;
  localparam int WORD_W    = 32;
  localparam int TIME_W    = 32;
  localparam int TO_W      = 16;

  // Word a lane shows when nothing was received
  localparam logic [WORD_W-1:0] NO_WORD = '1;

  localparam logic [TO_W-1:0]   PRESYNC_TO_RST = 16'd1000;
  localparam logic [TO_W-1:0]   SYNC_TO_RST    = 16'd800;
  localparam logic [WORD_W-1:0] SYNC_WORD_RST  = 32'd15;

  // Register indexes, byte address 4*index
  localparam logic [1:0] REG_PRESYNC_TO = 2'd0;
  localparam logic [1:0] REG_SYNC_TO    = 2'd1;
  localparam logic [1:0] REG_SYNC_WORD  = 2'd2;

  localparam logic OP_START = 1'b0;
  localparam logic OP_POLL  = 1'b1;

  typedef struct packed {
    logic [TO_W-1:0]   presync_timeout;
    logic [TO_W-1:0]   sync_timeout;
    logic [WORD_W-1:0] sync_word;
  } cfg_t;

  typedef struct packed {
    logic match;
    logic silent;
  } lane_flags_t;

  typedef struct packed {
    logic                 send_sync;
    logic                 done_res;
    logic [MAX_LANES-1:0] fail_mask;
    logic [MAX_LANES-1:0] navail_mask;
  } res_t;

endpackage

/* rtl/cross_lane_sync_voter.sv */
// Cross-lane sync voter: takes one word per clock when in_stall is low. Each
// word is decided in the cycle it is accepted: the lane checkers and the
// merge stage update the handshake state in that one clock, and a result
// is registered in the output or skid entry. Sustained rate is one word per
// cycle; in_stall rises only when the output register and its skid entry are
// both full. A start word opens pre-sync; polls end a phase on their second
// satisfied or timed-out occurrence, giving send_sync at the end of pre-sync
// and done_res with the lane masks at the end of sync. Registers sit at byte
// addresses 0 (pre-sync timeout), 4 (sync timeout) and 8 (sync word).
// Depends on clsv_pkg, clsv_lane, clsv_merge and clsv_skid.
module cross_lane_sync_voter #(
  parameter int LANES = 4
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [3:0]                         paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               operation,
  input  logic [clsv_pkg::MAX_LANES-1:0]     lane_off_mask,
  input  logic [clsv_pkg::MAX_LANES-1:0]     lane_iso_mask,
  input  logic [clsv_pkg::TIME_W-1:0]        time_now,
  input  logic signed [clsv_pkg::WORD_W-1:0] word_lane0,
  input  logic signed [clsv_pkg::WORD_W-1:0] word_lane1,
  input  logic signed [clsv_pkg::WORD_W-1:0] word_lane2,
  input  logic signed [clsv_pkg::WORD_W-1:0] word_lane3,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               send_sync,
  output logic                               done_res,
  output logic [clsv_pkg::MAX_LANES-1:0]     fail_mask,
  output logic [clsv_pkg::MAX_LANES-1:0]     navail_mask
);

  clsv_pkg::cfg_t        cfg;
  logic                  cfg_wr;
  logic                  accept;
  logic [clsv_pkg::WORD_W-1:0] words [clsv_pkg::MAX_LANES];
  clsv_pkg::lane_flags_t flags [clsv_pkg::MAX_LANES];
  logic                  res_valid;
  clsv_pkg::res_t        res;
  clsv_pkg::res_t        out_word;
  logic                  full;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.presync_timeout <= clsv_pkg::PRESYNC_TO_RST;
      cfg.sync_timeout    <= clsv_pkg::SYNC_TO_RST;
      cfg.sync_word       <= clsv_pkg::SYNC_WORD_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        clsv_pkg::REG_PRESYNC_TO: cfg.presync_timeout <= pwdata[15:0];
        clsv_pkg::REG_SYNC_TO:    cfg.sync_timeout    <= pwdata[15:0];
        clsv_pkg::REG_SYNC_WORD:  cfg.sync_word       <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      clsv_pkg::REG_PRESYNC_TO: prdata = {16'd0, cfg.presync_timeout};
      clsv_pkg::REG_SYNC_TO:    prdata = {16'd0, cfg.sync_timeout};
      clsv_pkg::REG_SYNC_WORD:  prdata = cfg.sync_word;
      default:                  prdata = '0;
    endcase
  end

  assign in_stall = full;
  assign accept   = in_valid && !in_stall;

  assign words[0] = word_lane0;
  assign words[1] = word_lane1;
  assign words[2] = word_lane2;
  assign words[3] = word_lane3;

  for (genvar l = 0; l < clsv_pkg::MAX_LANES; l++) begin : g_lane
    if (l < LANES) begin : g_on
      clsv_lane u_lane (
        .word      (words[l]),
        .sync_word (cfg.sync_word),
        .flags     (flags[l])
      );
    end else begin : g_off
      assign flags[l] = '0;
    end
  end

  clsv_merge #(
    .LANES (LANES)
  ) u_merge (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .operation     (operation),
    .lane_off_mask (lane_off_mask),
    .lane_iso_mask (lane_iso_mask),
    .time_now      (time_now),
    .flags         (flags),
    .cfg           (cfg),
    .res_valid     (res_valid),
    .res           (res)
  );

  clsv_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res       (res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_word  (out_word),
    .full      (full)
  );

  assign send_sync   = out_word.send_sync;
  assign done_res    = out_word.done_res;
  assign fail_mask   = out_word.fail_mask;
  assign navail_mask = out_word.navail_mask;

endmodule

/* rtl/clsv_lane.sv */
// One lane of the voter: checks the received word against the sync word and flags a silent lane.
// Depends on clsv_pkg.
module clsv_lane (
  input  logic [clsv_pkg::WORD_W-1:0] word,
  input  logic [clsv_pkg::WORD_W-1:0] sync_word,
  output clsv_pkg::lane_flags_t       flags
);

  always_comb begin
    flags.match  = (word == sync_word);
    flags.silent = (word == clsv_pkg::NO_WORD);
  end

endmodule

/* rtl/clsv_merge.sv */
// Merge stage and handshake state: combines the lane flags, keeps counts,
// phase and timing, and produces at most one result per word.
// Depends on clsv_pkg.
module clsv_merge #(
  parameter int LANES = 4
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                accept,
  input  logic                                operation,
  input  logic [clsv_pkg::MAX_LANES-1:0]      lane_off_mask,
  input  logic [clsv_pkg::MAX_LANES-1:0]      lane_iso_mask,
  input  logic [clsv_pkg::TIME_W-1:0]         time_now,
  input  clsv_pkg::lane_flags_t               flags [clsv_pkg::MAX_LANES],
  input  clsv_pkg::cfg_t                      cfg,
  output logic                                res_valid,
  output clsv_pkg::res_t                      res
);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_PRESYNC,
    PH_SYNC
  } phase_t;

  localparam logic [clsv_pkg::MAX_LANES-1:0] LaneMask =
    clsv_pkg::MAX_LANES'((1 << LANES) - 1);

  phase_t                        phase;
  logic [1:0]                    end_count;
  logic [1:0]                    correct_count;
  logic [1:0]                    needed_min;
  logic [2:0]                    healthy_count;
  logic [clsv_pkg::TIME_W-1:0]   phase_start;
  logic [clsv_pkg::MAX_LANES-1:0] good_mask;

  logic [clsv_pkg::MAX_LANES-1:0] match_vec;
  logic [clsv_pkg::MAX_LANES-1:0] silent_vec;
  logic [clsv_pkg::MAX_LANES-1:0] good_next;
  logic [clsv_pkg::MAX_LANES-1:0] bad;
  logic [2:0]                    healthy_next;
  logic [2:0]                    match_cnt;
  logic [2:0]                    cc_sum;
  logic [1:0]                    correct_next;
  logic [clsv_pkg::TIME_W-1:0]   elapsed;
  logic [clsv_pkg::TO_W-1:0]     limit;
  logic                          phase_hit;
  logic [1:0]                    end_next;
  logic                          poll_live;

  always_comb begin
    bad          = (lane_off_mask | lane_iso_mask) & LaneMask;
    healthy_next = '0;
    match_cnt    = '0;
    for (int i = 0; i < clsv_pkg::MAX_LANES; i++) begin
      match_vec[i]  = flags[i].match & LaneMask[i];
      silent_vec[i] = flags[i].silent & LaneMask[i];
      healthy_next  = healthy_next + 3'(LaneMask[i] & ~bad[i]);
      match_cnt     = match_cnt + 3'(match_vec[i]);
    end
    good_next    = good_mask | match_vec;
    cc_sum       = {1'b0, correct_count} + match_cnt;
    correct_next = (cc_sum > 3'd3) ? 2'd3 : cc_sum[1:0];
    elapsed      = time_now - phase_start;
    limit        = (phase == PH_PRESYNC) ? cfg.presync_timeout : cfg.sync_timeout;
    phase_hit    = (correct_next >= needed_min) ||
                   (elapsed > {{(clsv_pkg::TIME_W-clsv_pkg::TO_W){1'b0}}, limit});
    end_next     = end_count + 2'(phase_hit);
    poll_live    = accept && (operation == clsv_pkg::OP_POLL) && (phase != PH_IDLE);

    res_valid       = poll_live && (end_next == 2'd2);
    res.send_sync   = (phase == PH_PRESYNC);
    res.done_res    = (phase == PH_SYNC);
    res.fail_mask   = (phase == PH_SYNC) ? (~good_next & ~silent_vec & LaneMask) : '0;
    res.navail_mask = (phase == PH_SYNC) ? (~good_next & LaneMask) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      end_count     <= '0;
      correct_count <= '0;
      needed_min    <= '0;
      healthy_count <= '0;
      phase_start   <= '0;
      good_mask     <= '0;
    end else if (accept && operation == clsv_pkg::OP_START) begin
      healthy_count <= healthy_next;
      if (healthy_next >= 3'd3) begin
        needed_min <= 2'd2;
      end else if (healthy_next == 3'd2) begin
        needed_min <= 2'd1;
      end else begin
        needed_min <= 2'd0;
      end
      good_mask     <= '0;
      correct_count <= '0;
      end_count     <= '0;
      phase_start   <= time_now;
      phase         <= PH_PRESYNC;
    end else if (poll_live) begin
      good_mask     <= good_next;
      correct_count <= correct_next;
      if (end_next == 2'd2) begin
        end_count <= '0;
        if (phase == PH_PRESYNC) begin
          // open sync; the correct count carries over
          phase       <= PH_SYNC;
          phase_start <= time_now;
          if (healthy_count >= 3'd2) begin
            needed_min <= 2'd1;
          end
        end else begin
          phase <= PH_IDLE;
        end
      end else begin
        end_count <= end_next;
      end
    end
  end

  a_end_count_range: assert property (@(posedge clk) disable iff (rst)
    end_count != 2'd3)
    else $error("end count out of range");

  a_res_exclusive: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res.send_sync ^ res.done_res))
    else $error("result is neither send-sync nor done");

  a_presync_to_sync: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.send_sync) |=> (phase == PH_SYNC))
    else $error("send-sync did not open the sync phase");

  a_done_to_idle: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.done_res) |=> (phase == PH_IDLE))
    else $error("done result did not close the handshake");

endmodule

/* rtl/clsv_skid.sv */
// Output register with one skid entry, so a result can be parked while the
// output word is stalled. Depends on clsv_pkg.
module clsv_skid (
  input  logic           clk,
  input  logic           rst,
  input  logic           res_valid,
  input  clsv_pkg::res_t res,
  input  logic           out_stall,
  output logic           out_valid,
  output clsv_pkg::res_t out_word,
  output logic           full
);

  logic           skid_valid;
  clsv_pkg::res_t skid_word;

  assign full = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_valid && out_stall) begin
      // hold the output word, park a new result
      if (res_valid) begin
        skid_valid <= 1'b1;
        skid_word  <= res;
      end
    end else if (skid_valid) begin
      out_valid  <= 1'b1;
      out_word   <= skid_word;
      skid_valid <= res_valid;
      skid_word  <= res;
    end else begin
      out_valid <= res_valid;
      out_word  <= res;
    end
  end

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry filled while output register empty");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(skid_valid && res_valid && out_stall))
    else $error("result arrived with skid entry full");

  a_skid_drains: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && !out_stall) |=> out_valid)
    else $error("skid entry lost");

endmodule

/* test/cross_lane_sync_voter_check.sv */
`timescale 1ns / 100ps
// Scoreboard for cross_lane_sync_voter: snoops the APB port and both word channels,
// predicts the handshake results and compares them. Depends on clsv_pkg.
module cross_lane_sync_voter_check #(
  parameter int LANES = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic [31:0] prdata,
  input  logic        pready,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        operation,
  input  logic [3:0]  lane_off_mask,
  input  logic [3:0]  lane_iso_mask,
  input  logic [31:0] time_now,
  input  logic signed [31:0] word_lane0,
  input  logic signed [31:0] word_lane1,
  input  logic signed [31:0] word_lane2,
  input  logic signed [31:0] word_lane3,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        send_sync,
  input  logic        done_res,
  input  logic [3:0]  fail_mask,
  input  logic [3:0]  navail_mask,
  output int          pending,
  output int          fail_count
);
  import clsv_pkg::*;

  typedef enum logic [1:0] {PH_IDLE, PH_PRESYNC, PH_SYNC} hs_phase_t;

  localparam logic [3:0] LIVE_LANES = 4'((1 << LANES) - 1);

  cfg_t        cfg;
  hs_phase_t   phase;
  logic [1:0]  end_cnt;
  logic [1:0]  correct_cnt;
  logic [1:0]  need_cnt;
  logic [2:0]  healthy_cnt;
  logic [31:0] phase_t0;
  logic [3:0]  good_m;
  logic [3:0]  silent_m;
  res_t        sync_results_due[$];

  initial begin
    pending    = 0;
    fail_count = 0;
  end

  task automatic report_mismatch(input string what);
    $display("check: mismatch at %0t ns: %s", $time, what);
    fail_count++;
  endtask

  task automatic clear_handshake();
    phase       = PH_IDLE;
    end_cnt     = '0;
    correct_cnt = '0;
    need_cnt    = '0;
    healthy_cnt = '0;
    phase_t0    = '0;
    good_m      = '0;
    silent_m    = '1;
  endtask

  // Update the handshake state for one accepted word; queue its result if any.
  task automatic advance_handshake(input logic op, input logic [3:0] off_m,
                                   input logic [3:0] iso_m, input logic [31:0] now,
                                   input logic [3:0][31:0] words);
    logic [3:0]  bad;
    logic [31:0] limit;
    logic [31:0] elapsed;
    res_t        r;
    if (op == OP_START) begin
      bad = off_m | iso_m;
      healthy_cnt = '0;
      for (int i = 0; i < LANES; i++)
        if (!bad[i]) healthy_cnt++;
      if (healthy_cnt >= 3) need_cnt = 2'd2;
      else if (healthy_cnt == 2) need_cnt = 2'd1;
      else need_cnt = 2'd0;
      good_m      = '0;
      silent_m    = '1;
      correct_cnt = '0;
      end_cnt     = '0;
      phase_t0    = now;
      phase       = PH_PRESYNC;
      return;
    end
    // polls outside a handshake are dropped
    if (phase == PH_IDLE) return;
    silent_m = '0;
    for (int i = 0; i < LANES; i++) begin
      if (words[i] == cfg.sync_word) begin
        good_m[i] = 1'b1;
        if (correct_cnt != 2'd3) correct_cnt++;
      end
      if (words[i] == NO_WORD) silent_m[i] = 1'b1;
    end
    limit   = (phase == PH_PRESYNC) ? 32'(cfg.presync_timeout) : 32'(cfg.sync_timeout);
    elapsed = now - phase_t0;
    if (correct_cnt >= need_cnt || elapsed > limit) end_cnt++;
    if (end_cnt < 2) return;
    end_cnt = '0;
    r = '0;
    if (phase == PH_PRESYNC) begin
      phase    = PH_SYNC;
      phase_t0 = now;
      if (healthy_cnt >= 2) need_cnt = 2'd1;
      r.send_sync = 1'b1;
    end else begin
      phase         = PH_IDLE;
      r.done_res    = 1'b1;
      r.fail_mask   = ~good_m & ~silent_m & LIVE_LANES;
      r.navail_mask = ~good_m & LIVE_LANES;
    end
    sync_results_due.push_back(r);
  endtask

  task automatic check_result();
    res_t got;
    res_t want;
    got = '{send_sync, done_res, fail_mask, navail_mask};
    if (sync_results_due.size() == 0) begin
      report_mismatch($sformatf("unexpected result %p", got));
      return;
    end
    want = sync_results_due.pop_front();
    if (got.send_sync !== want.send_sync)
      report_mismatch($sformatf("send_sync %b, want %b", got.send_sync, want.send_sync));
    if (got.done_res !== want.done_res)
      report_mismatch($sformatf("done_res %b, want %b", got.done_res, want.done_res));
    if (got.fail_mask !== want.fail_mask)
      report_mismatch($sformatf("fail_mask %b, want %b", got.fail_mask, want.fail_mask));
    if (got.navail_mask !== want.navail_mask)
      report_mismatch($sformatf("navail_mask %b, want %b", got.navail_mask,
                                want.navail_mask));
  endtask

  task automatic track_apb();
    logic [31:0] want;
    logic        known;
    known = 1'b1;
    want  = '0;
    case (paddr[3:2])
      REG_PRESYNC_TO: begin
        if (pwrite) cfg.presync_timeout = pwdata[15:0];
        want = 32'(cfg.presync_timeout);
      end
      REG_SYNC_TO: begin
        if (pwrite) cfg.sync_timeout = pwdata[15:0];
        want = 32'(cfg.sync_timeout);
      end
      REG_SYNC_WORD: begin
        if (pwrite) cfg.sync_word = pwdata;
        want = cfg.sync_word;
      end
      default: known = 1'b0;
    endcase
    if (!pwrite && known && prdata !== want)
      report_mismatch($sformatf("register %0d reads %h, want %h", paddr[3:2], prdata, want));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      cfg.presync_timeout = PRESYNC_TO_RST;
      cfg.sync_timeout    = SYNC_TO_RST;
      cfg.sync_word       = SYNC_WORD_RST;
      clear_handshake();
      sync_results_due.delete();
    end else begin
      if (out_valid && !out_stall) check_result();
      if (psel && penable && pready) track_apb();
      if (in_valid && !in_stall)
        advance_handshake(operation, lane_off_mask, lane_iso_mask, time_now,
                          {word_lane3, word_lane2, word_lane1, word_lane0});
    end
    pending <= sync_results_due.size();
  end

endmodule

/* test/cross_lane_sync_voter_test.sv */
`timescale 1ns / 100ps
// Testbench top for cross_lane_sync_voter: clock, reset, register setup and word
// stimulus, plus the verdict. Depends on clsv_pkg, the block and its scoreboard.
module cross_lane_sync_voter_test;
  import clsv_pkg::*;

  localparam int RUN_LIMIT   = 400000;
  localparam int PHASE_WORDS = 178;
  localparam int HOLD_CYCLES = 150;
  localparam logic [1:0] REG_UNUSED = 2'd3;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        operation = OP_START;
  logic [3:0]  lane_off_mask = '0;
  logic [3:0]  lane_iso_mask = '0;
  logic [31:0] time_now = '0;
  logic signed [31:0] word_lane0 = '0;
  logic signed [31:0] word_lane1 = '0;
  logic signed [31:0] word_lane2 = '0;
  logic signed [31:0] word_lane3 = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        send_sync;
  logic        done_res;
  logic [3:0]  fail_mask;
  logic [3:0]  navail_mask;
  int          pending;
  int          fail_count;

  logic        recv_hold = 1'b0;
  int          recv_stall_pct = 0;
  int          send_idle_pct = 0;
  int          cycle_count = 0;
  logic [31:0] clock_ms = '0;
  logic [31:0] cur_sync_word = SYNC_WORD_RST;
  int          time_span = 1002;

  cross_lane_sync_voter u_top (.*);

  cross_lane_sync_voter_check u_check (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (recv_hold) out_stall <= 1'b1;
    else out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic hold_receiver(input int cycles);
    recv_hold <= 1'b1;
    repeat (cycles) @(posedge clk);
    recv_hold <= 1'b0;
  endtask

  task automatic apb_access(input logic wr, input logic [1:0] idx, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Offer one word after a random gap, hold it until accepted.
  task automatic put_word(input logic op, input logic [3:0] off_m, input logic [3:0] iso_m,
                          input logic [31:0] now, input logic [3:0][31:0] w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    operation     <= op;
    lane_off_mask <= off_m;
    lane_iso_mask <= iso_m;
    time_now      <= now;
    word_lane0    <= w[0];
    word_lane1    <= w[1];
    word_lane2    <= w[2];
    word_lane3    <= w[3];
    in_valid      <= 1'b1;
    do @(posedge clk); while (in_stall);
  endtask

  // Stop sending and wait until every due result has been taken.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_setting(input logic [15:0] pre_to, input logic [15:0] sync_to,
                              input logic [31:0] sw);
    apb_access(1'b1, REG_PRESYNC_TO, 32'(pre_to));
    apb_access(1'b1, REG_SYNC_TO, 32'(sync_to));
    apb_access(1'b1, REG_SYNC_WORD, sw);
    apb_access(1'b1, REG_UNUSED, $urandom);
    apb_access(1'b0, REG_PRESYNC_TO, '0);
    apb_access(1'b0, REG_SYNC_TO, '0);
    apb_access(1'b0, REG_SYNC_WORD, '0);
    cur_sync_word = sw;
    time_span = ((pre_to > sync_to) ? int'(pre_to) : int'(sync_to)) + 2;
  endtask

  // Mostly small steps, some around the timeouts, a few wild jumps.
  function automatic logic [31:0] next_time();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 60) clock_ms = clock_ms + $urandom_range(20);
    else if (pick < 92) clock_ms = clock_ms + $urandom_range(time_span);
    else clock_ms = $urandom;
    return clock_ms;
  endfunction

  function automatic logic [31:0] lane_word(input logic hit);
    int unsigned pick;
    pick = $urandom_range(99);
    if (hit) return cur_sync_word;
    if (pick < 40) return NO_WORD;
    if (pick < 70) return $urandom;
    if (pick < 90) return cur_sync_word ^ (32'd1 << $urandom_range(31));
    return cur_sync_word;
  endfunction

  task automatic poll_lanes(input int hit_pct);
    logic [3:0][31:0] w;
    logic [31:0]      now;
    for (int i = 0; i < 4; i++) w[i] = lane_word($urandom_range(99) < hit_pct);
    now = next_time();
    put_word(OP_POLL, 4'($urandom), 4'($urandom), now, w);
  endtask

  task automatic open_handshake();
    logic [3:0]  off_m;
    logic [3:0]  iso_m;
    logic [31:0] now;
    off_m = ($urandom_range(99) < 50) ? 4'b0000 : 4'($urandom);
    iso_m = ($urandom_range(99) < 50) ? 4'b0000 : 4'($urandom);
    now   = next_time();
    put_word(OP_START, off_m, iso_m, now, {$urandom, $urandom, $urandom, $urandom});
  endtask

  task automatic run_handshake(output int sent);
    int polls;
    int hit_pct;
    polls   = $urandom_range(10, 2);
    hit_pct = $urandom_range(100);
    open_handshake();
    for (int p = 0; p < polls; p++) poll_lanes(hit_pct);
    sent = polls + 1;
  endtask

  initial begin
    int batch;
    int sent;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Lane words below are listed lane 3 first.
    // poll with no handshake open: dropped
    put_word(OP_POLL, 4'hF, 4'hF, 32'd0, {32'd15, 32'd15, 32'd15, 32'd15});
    // all lanes healthy, count saturates, ends on satisfied polls
    put_word(OP_START, 4'h0, 4'h0, 32'd0, {32'h7FFF_FFFF, 32'h8000_0000, 32'd0, NO_WORD});
    put_word(OP_POLL, 4'h0, 4'h0, 32'd1, {32'd15, 32'd15, 32'd15, 32'd15});
    put_word(OP_POLL, 4'h0, 4'h0, 32'd2, {32'h8000_0000, 32'h7FFF_FFFF, 32'd15, NO_WORD});
    put_word(OP_POLL, 4'h0, 4'h0, 32'd3, {32'd15, 32'd15, NO_WORD, 32'd0});
    put_word(OP_POLL, 4'h0, 4'h0, 32'd4, {32'd0, NO_WORD, NO_WORD, 32'd16});
    // no healthy lane, time wraps, corrupt and silent lanes at the end
    put_word(OP_START, 4'hF, 4'hF, 32'hFFFF_FFF0, {4{NO_WORD}});
    put_word(OP_POLL, 4'h0, 4'h0, 32'hFFFF_FFFF, {4{NO_WORD}});
    put_word(OP_POLL, 4'h0, 4'h0, 32'd5, {NO_WORD, 32'd3, 32'd2, 32'd1});
    put_word(OP_POLL, 4'h0, 4'h0, 32'd6, {32'd0, 32'hFFFF_FFFE, NO_WORD, 32'h8000_0000});
    put_word(OP_POLL, 4'h0, 4'h0, 32'd7, {32'h7FFF_FFFF, NO_WORD, NO_WORD, NO_WORD});
    // two healthy lanes, timeout boundary: equal does not count, one more does
    put_word(OP_START, 4'h1, 4'h2, 32'd5000, {4{NO_WORD}});
    put_word(OP_POLL, 4'h0, 4'h0, 32'd6000, {4{NO_WORD}});
    put_word(OP_POLL, 4'h0, 4'h0, 32'd6001, {4{NO_WORD}});
    // restart mid-handshake, count carries into sync, sync timeout
    put_word(OP_START, 4'h0, 4'h8, 32'd7000, {4{NO_WORD}});
    put_word(OP_POLL, 4'h0, 4'h0, 32'd7001, {NO_WORD, 32'd15, NO_WORD, NO_WORD});
    put_word(OP_POLL, 4'h0, 4'h0, 32'd8000, {NO_WORD, NO_WORD, 32'd15, NO_WORD});
    put_word(OP_POLL, 4'h0, 4'h0, 32'd8000, {4{NO_WORD}});
    put_word(OP_POLL, 4'h0, 4'h0, 32'd8801, {4{NO_WORD}});
    put_word(OP_POLL, 4'h0, 4'h0, 32'd8801, {NO_WORD, NO_WORD, NO_WORD, 32'd16});
    drain();

    for (int k = 0; k < 8; k++) begin
      case (k)
        0: load_setting(PRESYNC_TO_RST, SYNC_TO_RST, SYNC_WORD_RST);
        1: load_setting(16'd0, 16'd0, NO_WORD);
        2: load_setting(16'hFFFF, 16'hFFFF, 32'h8000_0000);
        3: load_setting(16'd50, 16'd30, 32'h7FFF_FFFF);
        4: load_setting(16'($urandom), 16'($urandom), $urandom);
        5: load_setting(16'd0, 16'hFFFF, 32'd0);
        6: load_setting(16'hFFFF, 16'd0, $urandom);
        default: load_setting(16'($urandom_range(200)), 16'($urandom_range(200)), 32'd15);
      endcase
      case (k % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
        1: begin send_idle_pct = 88; recv_stall_pct <= 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct <= 88; end
        default: begin send_idle_pct = 10; recv_stall_pct <= 10; end
      endcase
      if (k == 0) begin
        // hold the output while clean handshakes keep coming, so the input backs up
        fork
          hold_receiver(HOLD_CYCLES);
        join_none
        repeat (6) begin
          open_handshake();
          repeat (4) poll_lanes(100);
        end
        drain();
      end
      batch = 0;
      while (batch < PHASE_WORDS) begin
        if ($urandom_range(99) < 8) poll_lanes($urandom_range(100));
        else begin
          run_handshake(sent);
          batch += sent;
        end
      end
      drain();
    end

    if (fail_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

/* filelist.f */
rtl/clsv_pkg.sv
rtl/clsv_lane.sv
rtl/clsv_merge.sv
rtl/clsv_skid.sv
rtl/cross_lane_sync_voter.sv
test/cross_lane_sync_voter_check.sv
test/cross_lane_sync_voter_test.sv
